// ===== rtl/pm_pkg.sv =====
// ----------------------------------------------------------------------------
// pm_pkg
// Types, constants and helpers shared by the polynomial multiplier modules.
// ----------------------------------------------------------------------------
package pm_pkg;

    localparam int MAX_TERMS = 16;
    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int ACC_W     = 72;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int LEN_W     = 5;
    localparam int CNT_W     = LEN_W + 1;
    localparam int K_W       = LEN_W;

    // configuration register indexes
    localparam logic REG_LEN_A = 1'b0;
    localparam logic REG_LEN_B = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN
    } pm_state_t;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              out_load;
        logic              out_last;
    } pm_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } pm_status_t;

    // a length of zero acts as one, anything above MAX_TERMS as MAX_TERMS
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if ({1'b0, v} > CNT_W'(MAX_TERMS)) begin
            r = LEN_W'(MAX_TERMS);
        end
        return r;
    endfunction

    // lowest A index that contributes to product term k
    function automatic logic [ADDR_W-1:0] first_index(input logic [K_W-1:0] k,
                                                      input logic [LEN_W-1:0] lb);
        logic [ADDR_W-1:0] r;
        r = '0;
        if (k >= lb) begin
            r = ADDR_W'(k - lb + K_W'(1));
        end
        return r;
    endfunction

endpackage

// ===== rtl/polynomial_multiply.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply
// Convolution of two Q16.16 polynomials with one shared multiply-accumulate.
// ----------------------------------------------------------------------------
//  channel   direction  payload                          handshake
//  cfg       in         cfg_index, cfg_data              cfg_valid / cfg_ready
//  s         in         s_coef_in (A then B, low first)  s_valid / s_ready
//  m         out        m_coef_out, m_saturated, m_last  m_valid / m_ready
//
//  While loading, every request is taken. After the last B coefficient the
//  sequencer walks the product terms: each term k issues its operand pairs
//  to the multiplier, then drains through the read, multiply and accumulate
//  registers. A stall on m holds the sequencer before the next term.
//  s_ready is low until the last term sits in the output register.
//  Reset clears the lengths to one, the load count and the accumulator.
// ----------------------------------------------------------------------------
module polynomial_multiply (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [pm_pkg::LEN_W-1:0]         cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [pm_pkg::COEF_W-1:0] s_coef_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [pm_pkg::COEF_W-1:0] m_coef_out,
    output logic                             m_saturated,
    output logic                             m_last
);
    import pm_pkg::*;

    pm_cmd_t    cmd;
    pm_status_t status;

    pm_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pm_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_coef_in   (s_coef_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_coef_out  (m_coef_out),
        .m_saturated (m_saturated),
        .m_last      (m_last)
    );

endmodule

// ===== rtl/pm_datapath.sv =====
// ----------------------------------------------------------------------------
// pm_datapath
// Operand stores, multiply-accumulate pipeline, result rounding and output
// register.
// ----------------------------------------------------------------------------
module pm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pm_pkg::pm_cmd_t               cmd,
    output pm_pkg::pm_status_t            status,
    input  logic signed [pm_pkg::COEF_W-1:0] s_coef_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [pm_pkg::COEF_W-1:0] m_coef_out,
    output logic                          m_saturated,
    output logic                          m_last
);
    import pm_pkg::*;

    logic signed [COEF_W-1:0] a_mem [MAX_TERMS];
    logic signed [COEF_W-1:0] b_mem [MAX_TERMS];

    logic signed [COEF_W-1:0] a_q_reg;
    logic signed [COEF_W-1:0] b_q_reg;
    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic signed [COEF_W-1:0] coef_out_reg;
    logic                     sat_reg;
    logic                     last_reg;
    logic                     m_valid_reg;

    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-COEF_W:0]    upper;
    logic signed [COEF_W-1:0] result;
    logic                     result_sat;

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            a_mem[cmd.wr_addr] <= s_coef_in;
        end
        if (cmd.wr_b) begin
            b_mem[cmd.wr_addr] <= s_coef_in;
        end
        a_q_reg  <= a_mem[cmd.rd_a_addr];
        b_q_reg  <= b_mem[cmd.rd_b_addr];
        prod_reg <= a_q_reg * b_q_reg;
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.out_load) begin
            acc_next = '0;
        end else if (v2_reg) begin
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // floor to Q16.16 and clip to the 32-bit range
    always_comb begin
        shifted    = acc_reg >>> FRAC_BITS;
        upper      = shifted[ACC_W-1:COEF_W-1];
        result     = shifted[COEF_W-1:0];
        result_sat = 1'b0;
        if (upper != '0 && upper != '1) begin
            result_sat = 1'b1;
            result     = acc_reg[ACC_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                          : {1'b0, {(COEF_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg  <= cmd.issue;
            v2_reg  <= v1_reg;
            acc_reg <= acc_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            coef_out_reg <= result;
            sat_reg      <= result_sat;
            last_reg     <= cmd.out_last;
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_coef_out  = coef_out_reg;
    assign m_saturated = sat_reg;
    assign m_last      = last_reg;

endmodule

// ===== rtl/pm_controller.sv =====
// ----------------------------------------------------------------------------
// pm_controller
// Length registers, load counter and the sequencer that walks the product
// terms through the shared multiply-accumulate.
// ----------------------------------------------------------------------------
module pm_controller (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [pm_pkg::LEN_W-1:0]    cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    output pm_pkg::pm_cmd_t             cmd,
    input  pm_pkg::pm_status_t          status
);
    import pm_pkg::*;

    pm_state_t         state_reg, state_next;
    logic [LEN_W-1:0]  len_a_reg;
    logic [LEN_W-1:0]  len_b_reg;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [ADDR_W-1:0] i_reg, i_next;

    logic [LEN_W-1:0]  la;
    logic [LEN_W-1:0]  lb;
    logic [CNT_W-1:0]  total;
    logic [K_W-1:0]    k_final;
    logic [ADDR_W-1:0] i_hi;
    logic [CNT_W-1:0]  p_inc;
    logic [CNT_W-1:0]  pb;
    logic [K_W-1:0]    b_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_a_reg <= LEN_W'(1);
            len_b_reg <= LEN_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LEN_A: len_a_reg <= cfg_data;
                REG_LEN_B: len_b_reg <= cfg_data;
                default:   len_a_reg <= len_a_reg;
            endcase
        end
    end

    always_comb begin
        la      = eff_len(len_a_reg);
        lb      = eff_len(len_b_reg);
        total   = {1'b0, la} + {1'b0, lb};
        k_final = K_W'(total - CNT_W'(2));
        i_hi    = ((la - LEN_W'(1)) < k_reg) ? ADDR_W'(la - LEN_W'(1)) : ADDR_W'(k_reg);
        p_inc   = load_count_reg + CNT_W'(1);
        pb      = load_count_reg - {1'b0, la};
        b_idx   = k_reg - K_W'(i_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.rd_a_addr   = i_reg;
        cmd.rd_b_addr   = ADDR_W'(b_idx);
        cmd.out_last    = (k_reg == k_final);

        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (load_count_reg < {1'b0, la}) begin
                        cmd.wr_a    = 1'b1;
                        cmd.wr_addr = ADDR_W'(load_count_reg);
                    end else if (pb < CNT_W'(MAX_TERMS)) begin
                        // coefficients past the B store are dropped
                        cmd.wr_b    = 1'b1;
                        cmd.wr_addr = ADDR_W'(pb);
                    end
                    load_count_next = p_inc;
                    if (p_inc >= total) begin
                        load_count_next = '0;
                        k_next          = '0;
                        i_next          = '0;
                        state_next      = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                if (i_reg == i_hi) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_next = i_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land and the output register to be free, then hand the term over
                if (!status.pipe_busy && status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (k_reg == k_final) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + K_W'(1);
                        i_next     = first_index(k_reg + K_W'(1), lb);
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polynomial_multiply. Loads operand pairs at many
// lengths, including out-of-range length codes. An internal convolution model
// predicts every Q16.16 product coefficient with floor scaling, saturation and
// the last marker. Both handshake sides stall at random, and one long output
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pm_pkg::*;

    localparam int ITEMS       = 450;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_LIMIT  = 4000;

    localparam logic [COEF_W-1:0] CORNER_PAIRS [8] = '{
        32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h7FFF_FFFF,
        32'hFFFF_FFFF, 32'h0000_0001,
        32'h0001_0000, 32'h8000_0000
    };
    localparam logic [COEF_W-1:0] CORNER_B [9] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic                     sat;
        logic                     last;
    } product_t;

    class product_board;
        localparam int SUM_W = 72;
        localparam logic signed [SUM_W-1:0] Q_TOP    = 72'sh7FFF_FFFF;
        localparam logic signed [SUM_W-1:0] Q_BOTTOM = -72'sh8000_0000;

        logic signed [COEF_W-1:0] a_coefs [MAX_TERMS];
        logic signed [COEF_W-1:0] b_coefs [MAX_TERMS];
        logic [LEN_W-1:0]         len_a_reg;
        logic [LEN_W-1:0]         len_b_reg;
        int unsigned              loaded;
        product_t                 product_q [$];
        int                       errors;

        function new();
            len_a_reg = LEN_W'(1);
            len_b_reg = LEN_W'(1);
            loaded    = 0;
            errors    = 0;
        endfunction

        // zero counts as one term, anything past MAX_TERMS as MAX_TERMS
        function int unsigned terms(input logic [LEN_W-1:0] v);
            if (v == '0) return 1;
            if (v > MAX_TERMS) return MAX_TERMS;
            return v;
        endfunction

        function int unsigned set_size();
            return terms(len_a_reg) + terms(len_b_reg);
        endfunction

        function int pending();
            return product_q.size();
        endfunction

        function void write_length(input logic idx, input logic [LEN_W-1:0] v);
            if (idx == REG_LEN_A) begin
                len_a_reg = v;
            end else begin
                len_b_reg = v;
            end
        endfunction

        function void note_coef(input logic signed [COEF_W-1:0] c);
            int unsigned la;
            int unsigned lb;
            logic signed [SUM_W-1:0] sum;
            logic signed [SUM_W-1:0] x;
            logic signed [SUM_W-1:0] y;
            logic signed [SUM_W-1:0] scaled;
            product_t p;
            la = terms(len_a_reg);
            lb = terms(len_b_reg);
            if (loaded < la) begin
                a_coefs[loaded] = c;
            end else if (loaded - la < MAX_TERMS) begin
                b_coefs[loaded - la] = c;
            end
            loaded++;
            if (loaded < la + lb) return;
            loaded = 0;
            for (int k = 0; k < la + lb - 1; k++) begin
                sum = '0;
                for (int i = 0; i < la; i++) begin
                    if (k >= i && k - i < lb) begin
                        x = a_coefs[i];
                        y = b_coefs[k - i];
                        sum = sum + x * y;
                    end
                end
                // floor toward minus infinity, then clip to Q16.16
                scaled = sum >>> FRAC_BITS;
                p.sat = 1'b1;
                if (scaled > Q_TOP) begin
                    p.coef = 32'sh7FFF_FFFF;
                end else if (scaled < Q_BOTTOM) begin
                    p.coef = 32'sh8000_0000;
                end else begin
                    p.sat  = 1'b0;
                    p.coef = scaled[COEF_W-1:0];
                end
                p.last = (k == la + lb - 2);
                product_q = {product_q, p};
            end
        endfunction

        function void mismatch(input string what, input logic [COEF_W-1:0] want,
                               input logic [COEF_W-1:0] got);
            errors++;
            if (errors <= 40) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            end
        endfunction

        function void check_product(input logic signed [COEF_W-1:0] coef,
                                    input logic sat, input logic last);
            product_t want;
            if (product_q.size() == 0) begin
                errors++;
                if (errors <= 40) begin
                    $display("%0t: unexpected product, expected none actual %h sat %b last %b",
                             $time, coef, sat, last);
                end
                return;
            end
            want = product_q.pop_front();
            if (coef !== want.coef) mismatch("coef_out", want.coef, coef);
            if (sat !== want.sat) mismatch("saturated", want.sat, sat);
            if (last !== want.last) mismatch("last", want.last, last);
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [LEN_W-1:0]         cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [COEF_W-1:0] s_coef_in;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [COEF_W-1:0] m_coef_out;
    logic                     m_saturated;
    logic                     m_last;

    product_board board;
    bit           calm;
    bit           long_hold;
    int           offered;
    int           idle_cycles;

    polynomial_multiply dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_coef_in   (s_coef_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_coef_out  (m_coef_out),
        .m_saturated (m_saturated),
        .m_last      (m_last)
    );

    always #10 aclk = ~aclk;

    function automatic logic [COEF_W-1:0] pick_coef();
        logic [COEF_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: r = 32'h7FFF_FFFF;
            1: r = 32'h8000_0000;
            2, 3: ;
            4: r = {{14{r[17]}}, r[17:0]};
            default: r = {{7{r[24]}}, r[24:0]};
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_W'($urandom_range(17, 31));
            2: return LEN_W'(MAX_TERMS);
            3: return LEN_W'($urandom_range(5, 15));
            default: return LEN_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic offer_coef(input logic [COEF_W-1:0] c);
        s_valid   <= 1'b1;
        s_coef_in <= c;
        do @(posedge aclk); while (!s_ready);
        offered++;
    endtask

    task automatic rest_input(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_lengths(input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LEN_A;
        cfg_data  <= la;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_LEN_B;
        cfg_data  <= lb;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_operands(input int gap_odds);
        int unsigned n;
        int unsigned j;
        n = 1;
        j = 0;
        while (j < n) begin
            offer_coef(pick_coef());
            // read the size after a request so the board has seen the length write
            n = board.set_size();
            j++;
            if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
                rest_input($urandom_range(1, 18));
            end
        end
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] la;
        logic [LEN_W-1:0] lb;
        int               gap_odds;
        int               phase;
        board     = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LEN_A;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_coef_in = '0;
        calm      = 1'b0;
        long_hold = 1'b0;
        offered   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset lengths: single-term products at the range limits and floor
        for (int j = 0; j < 8; j++) begin
            offer_coef(CORNER_PAIRS[j]);
        end
        wait_drained();

        // zero length acts as one, oversized length as MAX_TERMS
        write_lengths('0, 5'd31);
        offer_coef(32'hFFFF_0000);
        for (int j = 0; j < MAX_TERMS; j++) begin
            offer_coef(j < 9 ? CORNER_B[j] : pick_coef());
        end

        phase = 0;
        while (offered < ITEMS) begin
            phase++;
            wait_drained();
            la = pick_length();
            lb = pick_length();
            if (phase == 1) begin
                la = 5'd31;
                lb = 5'd16;
            end else if (phase == 3) begin
                la = 5'd3;
                lb = 5'd3;
            end
            write_lengths(la, lb);
            calm     = (offered >= ITEMS - 60);
            gap_odds = $urandom_range(0, 4);
            if (phase == 3) begin
                // keep offering while the output side is held off
                long_hold = 1'b1;
                gap_odds  = 0;
            end
            repeat (phase == 3 ? 5 : $urandom_range(1, 4)) load_operands(gap_odds);
        end

        wait_drained();
        repeat (TAIL) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : sink
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_length(cfg_index, cfg_data);
            if (s_valid && s_ready) board.note_coef(s_coef_in);
            if (m_valid && m_ready) board.check_product(m_coef_out, m_saturated, m_last);
        end
    end

    // abort when no request moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_valid && s_ready)
                || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
